// File: src/dmfp_pkg.sv
// Package for the DNS message field parser: result item types, field codes
// and the default result queue depth. No dependencies.
package dmfp_pkg;

  localparam int RES_FIFO_DEPTH = 4;

  localparam logic [3:0] FC_ID       = 4'd0;
  localparam logic [3:0] FC_FLAGS    = 4'd1;
  localparam logic [3:0] FC_NAME_CH  = 4'd6;
  localparam logic [3:0] FC_NAME_END = 4'd7;
  localparam logic [3:0] FC_POINTER  = 4'd8;
  localparam logic [3:0] FC_TYPE     = 4'd9;
  localparam logic [3:0] FC_CLASS    = 4'd10;
  localparam logic [3:0] FC_TTL      = 4'd11;
  localparam logic [3:0] FC_RDLEN    = 4'd12;
  localparam logic [3:0] FC_RDATA    = 4'd13;
  localparam logic [3:0] FC_END      = 4'd14;

  typedef struct packed {
    logic [3:0]  field_code;
    logic [31:0] field_value;
    logic        in_answer;
    logic [15:0] record_number;
    logic        malformed;
    logic        truncated;
    logic        run_end;
  } res_item_t;

  // Results caused by one accepted byte: none, one or two
  typedef struct packed {
    logic [1:0] count;
    res_item_t  item0;
    res_item_t  item1;
  } res_pair_t;

endpackage

// File: src/dmfp_core.sv
// Parser state and next-state logic: one byte in, up to two result items out.
// Depends on dmfp_pkg.
module dmfp_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_wdata,
  input  logic                  accept,
  input  logic [7:0]            octet,
  input  logic                  last,
  output dmfp_pkg::res_pair_t   results
);

  typedef enum logic [10:0] {
    PH_HEADER = 11'b00000000001,
    PH_QNAME  = 11'b00000000010,
    PH_QTYPE  = 11'b00000000100,
    PH_QCLASS = 11'b00000001000,
    PH_ANAME  = 11'b00000010000,
    PH_ATYPE  = 11'b00000100000,
    PH_ACLASS = 11'b00001000000,
    PH_TTL    = 11'b00010000000,
    PH_RDLEN  = 11'b00100000000,
    PH_RDATA  = 11'b01000000000,
    PH_DONE   = 11'b10000000000
  } phase_t;

  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowZ  = 8'h7a;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5a;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChDash  = 8'h2d;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] PtrMark = 8'hc0;

  function automatic logic host_char(input logic [7:0] b);
    host_char = (b >= ChLowA && b <= ChLowZ) || (b >= ChUpA && b <= ChUpZ) ||
                (b >= ChZero && b <= ChNine) || (b == ChDash);
  endfunction

  logic [7:0]  name_limit;
  phase_t      phase, phase_next;
  logic [15:0] fbc, fbc_next;
  logic [31:0] acc, acc_next;
  logic [15:0] q_left, q_left_next;
  logic [15:0] a_left, a_left_next;
  logic [15:0] rec, rec_next;
  logic [7:0]  label_left, label_left_next;
  logic [7:0]  nbs, nbs_next;
  logic        bad, bad_next;
  logic        stopped, stopped_next;

  logic        p_emit;
  logic [3:0]  p_code;
  logic [31:0] p_value;
  logic        p_answer;
  logic        start_q, start_a, fail;
  logic [15:0] fbc_inc, fbc_dec, q_dec, a_dec;
  logic [15:0] acc16;
  logic [31:0] acc_sh;
  logic        is_answer;
  dmfp_pkg::res_item_t proc_item, end_item;

  always_comb begin
    phase_next      = phase;
    fbc_next        = fbc;
    acc_next        = acc;
    q_left_next     = q_left;
    a_left_next     = a_left;
    rec_next        = rec;
    label_left_next = label_left;
    nbs_next        = nbs;
    bad_next        = bad;
    stopped_next    = stopped;
    p_emit   = 1'b0;
    p_code   = dmfp_pkg::FC_ID;
    p_value  = '0;
    p_answer = 1'b0;
    start_q  = 1'b0;
    start_a  = 1'b0;
    fail     = 1'b0;
    fbc_inc  = fbc + 16'd1;
    fbc_dec  = fbc - 16'd1;
    q_dec    = q_left - 16'd1;
    a_dec    = a_left - 16'd1;
    acc16    = {acc[7:0], octet};
    acc_sh   = {acc[23:0], octet};
    is_answer = (phase == PH_ANAME);

    if (accept && !stopped) begin
      unique case (phase)
        PH_HEADER: begin
          acc_next = {16'd0, acc16};
          fbc_next = fbc_inc;
          if (!fbc_inc[0]) begin
            p_emit  = 1'b1;
            p_code  = 4'(fbc_inc[4:1] - 4'd1);
            p_value = {16'd0, acc16};
            if (fbc_inc == 16'd6) q_left_next = acc16;
            if (fbc_inc == 16'd8) a_left_next = acc16;
            acc_next = '0;
          end
          if (fbc_inc >= 16'd12) begin
            fbc_next = '0;
            rec_next = '0;
            if (q_left_next != 16'd0) start_q = 1'b1;
            else if (a_left_next != 16'd0) start_a = 1'b1;
            else phase_next = PH_DONE;
          end
        end
        PH_QNAME, PH_ANAME: begin
          if (nbs >= name_limit) begin
            fail = 1'b1;
          end else begin
            nbs_next = nbs + 8'd1;
            p_answer = is_answer;
            if (fbc == 16'd1) begin
              // second pointer byte closes the name
              p_emit     = 1'b1;
              p_code     = dmfp_pkg::FC_POINTER;
              p_value    = {24'd0, octet};
              fbc_next   = '0;
              phase_next = is_answer ? PH_ATYPE : PH_QTYPE;
            end else if (nbs == 8'd0) begin
              if (is_answer && octet == PtrMark) begin
                p_emit   = 1'b1;
                p_code   = dmfp_pkg::FC_POINTER;
                p_value  = {24'd0, octet};
                fbc_next = 16'd1;
              end else if (octet == 8'd0) begin
                fail = 1'b1;
              end else begin
                label_left_next = octet;
              end
            end else if (label_left != 8'd0) begin
              if (!host_char(octet)) begin
                fail = 1'b1;
              end else begin
                p_emit          = 1'b1;
                p_code          = dmfp_pkg::FC_NAME_CH;
                p_value         = {24'd0, octet};
                label_left_next = label_left - 8'd1;
              end
            end else if (octet == 8'd0) begin
              p_emit     = 1'b1;
              p_code     = dmfp_pkg::FC_NAME_END;
              fbc_next   = '0;
              acc_next   = '0;
              phase_next = is_answer ? PH_ATYPE : PH_QTYPE;
            end else begin
              // later length byte: emit the label separator
              p_emit          = 1'b1;
              p_code          = dmfp_pkg::FC_NAME_CH;
              p_value         = {24'd0, ChDot};
              label_left_next = octet;
            end
          end
        end
        PH_QTYPE, PH_ATYPE, PH_QCLASS, PH_ACLASS, PH_RDLEN: begin
          if (fbc_inc < 16'd2) begin
            acc_next = acc_sh;
            fbc_next = fbc_inc;
          end else begin
            fbc_next = '0;
            acc_next = '0;
            p_emit   = 1'b1;
            p_value  = {16'd0, acc_sh[15:0]};
            p_answer = (phase != PH_QTYPE) && (phase != PH_QCLASS);
            unique case (phase)
              PH_QTYPE: begin
                p_code     = dmfp_pkg::FC_TYPE;
                phase_next = PH_QCLASS;
              end
              PH_ATYPE: begin
                p_code     = dmfp_pkg::FC_TYPE;
                phase_next = PH_ACLASS;
              end
              PH_QCLASS: begin
                p_code      = dmfp_pkg::FC_CLASS;
                rec_next    = rec + 16'd1;
                q_left_next = q_dec;
                if (q_dec != 16'd0) begin
                  start_q = 1'b1;
                end else begin
                  rec_next = '0;
                  if (a_left != 16'd0) start_a = 1'b1;
                  else phase_next = PH_DONE;
                end
              end
              PH_ACLASS: begin
                p_code     = dmfp_pkg::FC_CLASS;
                phase_next = PH_TTL;
              end
              default: begin
                p_code = dmfp_pkg::FC_RDLEN;
                if (acc_sh[15:0] == 16'd0) begin
                  // empty rdata: flag it and close the record
                  bad_next    = 1'b1;
                  rec_next    = rec + 16'd1;
                  a_left_next = a_dec;
                  if (a_dec != 16'd0) start_a = 1'b1;
                  else phase_next = PH_DONE;
                end else begin
                  fbc_next   = acc_sh[15:0];
                  phase_next = PH_RDATA;
                end
              end
            endcase
          end
        end
        PH_TTL: begin
          if (fbc_inc < 16'd4) begin
            acc_next = acc_sh;
            fbc_next = fbc_inc;
          end else begin
            fbc_next   = '0;
            acc_next   = '0;
            p_emit     = 1'b1;
            p_code     = dmfp_pkg::FC_TTL;
            p_value    = acc_sh;
            p_answer   = 1'b1;
            phase_next = PH_RDLEN;
          end
        end
        PH_RDATA: begin
          p_emit   = 1'b1;
          p_code   = dmfp_pkg::FC_RDATA;
          p_value  = {24'd0, octet};
          p_answer = 1'b1;
          fbc_next = fbc_dec;
          if (fbc_dec == 16'd0) begin
            rec_next    = rec + 16'd1;
            a_left_next = a_dec;
            if (a_dec != 16'd0) start_a = 1'b1;
            else phase_next = PH_DONE;
          end
        end
        PH_DONE: begin
        end
        default: begin
          phase_next = PH_DONE;
        end
      endcase

      if (fail) begin
        bad_next     = 1'b1;
        stopped_next = 1'b1;
      end
      if (start_q || start_a) begin
        phase_next      = start_q ? PH_QNAME : PH_ANAME;
        nbs_next        = '0;
        label_left_next = '0;
        fbc_next        = '0;
        acc_next        = '0;
      end
    end

    proc_item.field_code    = p_code;
    proc_item.field_value   = p_value;
    proc_item.in_answer     = p_answer;
    proc_item.record_number = (phase == PH_HEADER) ? 16'd0 : rec;
    proc_item.malformed     = bad_next;
    proc_item.truncated     = 1'b0;
    proc_item.run_end       = !last;

    end_item.field_code    = dmfp_pkg::FC_END;
    end_item.field_value   = '0;
    end_item.in_answer     = 1'b0;
    end_item.record_number = '0;
    end_item.malformed     = bad_next;
    end_item.truncated     = !stopped_next && (phase_next != PH_DONE);
    end_item.run_end       = 1'b1;

    results.item1 = end_item;
    if (!accept) begin
      results.count = 2'd0;
      results.item0 = proc_item;
    end else if (p_emit) begin
      results.count = last ? 2'd2 : 2'd1;
      results.item0 = proc_item;
    end else begin
      results.count = last ? 2'd1 : 2'd0;
      results.item0 = end_item;
    end

    // the final byte restarts the parser for the next message
    if (accept && last) begin
      phase_next      = PH_HEADER;
      fbc_next        = '0;
      acc_next        = '0;
      q_left_next     = '0;
      a_left_next     = '0;
      rec_next        = '0;
      label_left_next = '0;
      nbs_next        = '0;
      bad_next        = 1'b0;
      stopped_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      name_limit <= 8'd255;
      phase      <= PH_HEADER;
      fbc        <= '0;
      acc        <= '0;
      q_left     <= '0;
      a_left     <= '0;
      rec        <= '0;
      label_left <= '0;
      nbs        <= '0;
      bad        <= 1'b0;
      stopped    <= 1'b0;
    end else begin
      if (cfg_we) name_limit <= cfg_wdata;
      phase      <= phase_next;
      fbc        <= fbc_next;
      acc        <= acc_next;
      q_left     <= q_left_next;
      a_left     <= a_left_next;
      rec        <= rec_next;
      label_left <= label_left_next;
      nbs        <= nbs_next;
      bad        <= bad_next;
      stopped    <= stopped_next;
    end
  end

  a_stop_implies_bad: assert property (@(posedge clk) disable iff (rst)
    stopped |-> bad) else $error("parser stopped without malformed flag");

  a_final_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && last) |=> (phase == PH_HEADER && !stopped && !bad))
    else $error("final byte did not restart the parser");

  a_two_needs_final: assert property (@(posedge clk) disable iff (rst)
    (results.count == 2'd2) |-> (accept && last))
    else $error("two results from a byte that is not final");

endmodule

// File: src/dmfp_res_fifo.sv
// Result queue: takes up to two result items per cycle, hands out one.
// Depends on dmfp_pkg.
module dmfp_res_fifo #(
  parameter int Depth = dmfp_pkg::RES_FIFO_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dmfp_pkg::res_pair_t  push,
  input  logic                 pop,
  output dmfp_pkg::res_item_t  head,
  output logic                 not_empty,
  output logic                 room_for_two
);

  localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam logic [CW-1:0] RoomMax = CW'(Depth - 2);
  localparam logic [PW-1:0] LastIdx = PW'(Depth - 1);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == LastIdx) ? '0 : p + PW'(1);
  endfunction

  dmfp_pkg::res_item_t entries [Depth];
  logic [PW-1:0] wr_ptr, rd_ptr, wr_ptr1;
  logic [CW-1:0] count;

  assign wr_ptr1      = ptr_inc(wr_ptr);
  assign head         = entries[rd_ptr];
  assign not_empty    = (count != '0);
  assign room_for_two = (count <= RoomMax);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) entries[wr_ptr] <= push.item0;
    if (push.count == 2'd2) entries[wr_ptr1] <= push.item1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      unique case (push.count)
        2'd1:    wr_ptr <= wr_ptr1;
        2'd2:    wr_ptr <= ptr_inc(wr_ptr1);
        default: wr_ptr <= wr_ptr;
      endcase
      if (pop && not_empty) rd_ptr <= ptr_inc(rd_ptr);
      count <= count + CW'(push.count) - CW'(pop && not_empty);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> (int'(count) + int'(push.count) <= Depth))
    else $error("result queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= Depth) else $error("result queue count out of range");

endmodule

// File: src/dns_message_field_parser.sv
// DNS message field parser, top level. Latency: results of a byte enter the
// queue at the accepting edge and are offered from the next cycle.
// Throughput: one byte per cycle; a final byte that also decodes a field
// yields two results and takes two output transactions. Input ready drops
// while the result queue has fewer than two free entries.
// Reset (synchronous): parser to header phase, name limit to 255, queue empty.
module dns_message_field_parser #(
  parameter int FIFO_DEPTH = dmfp_pkg::RES_FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] octet
  input  logic        s_tlast,   // final_octet
  output logic        m_tvalid,
  input  logic        m_tready,
  // [31:0] field_value, [32] in_answer, [48:33] record_number,
  // [49] malformed, [50] truncated, [55:51] zero
  output logic [55:0] m_tdata,
  output logic [3:0]  m_tuser,   // [3:0] field_code
  output logic        m_tlast    // run_end
);

  dmfp_pkg::res_pair_t results;
  dmfp_pkg::res_item_t head;
  logic accept;
  logic room_for_two;

  assign s_tready = room_for_two;
  assign accept   = s_tvalid && room_for_two;

  dmfp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .octet     (s_tdata),
    .last      (s_tlast),
    .results   (results)
  );

  dmfp_res_fifo #(
    .Depth (FIFO_DEPTH)
  ) u_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (results),
    .pop          (m_tready),
    .head         (head),
    .not_empty    (m_tvalid),
    .room_for_two (room_for_two)
  );

  assign m_tdata = {5'd0, head.truncated, head.malformed, head.record_number,
                    head.in_answer, head.field_value};
  assign m_tuser = head.field_code;
  assign m_tlast = head.run_end;

endmodule
